[sv/iat_pkg.sv]
// ----------------------------------------------------------------------------
// Indexed array table package
// Field widths, request and status codes and sequencer states shared by the
// interfaces and the table unit.
// ----------------------------------------------------------------------------
package iat_pkg;

   localparam int REQ_TYPE_WIDTH    = 3;
   localparam int INDEX_WIDTH       = 10;
   localparam int VALUE_WIDTH       = 32;
   localparam int COUNT_FIELD_WIDTH = 9;
   localparam int STATUS_WIDTH      = 2;

   // Common width for index, count and capacity compares (capacity <= 1024).
   localparam int CMP_WIDTH = 11;
   // Width used to extend or cut elements to and from the value fields.
   localparam int EXT_WIDTH = 64;

   typedef enum logic [REQ_TYPE_WIDTH-1:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_INSERT = 3'd2,
      OP_DELETE = 3'd3,
      OP_GET    = 3'd4,
      OP_SET    = 3'd5,
      OP_FIND   = 3'd6
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR = 3'd0,
      S_IDLE  = 3'd1,
      S_EXEC  = 3'd2,
      S_GET   = 3'd3,
      S_WALK  = 3'd4,
      S_FIN   = 3'd5
   } state_type;

endpackage

[sv/iat_ifs.sv]
// ----------------------------------------------------------------------------
// Indexed array table channels
// Valid/ready request and response channels with their payload fields.
// ----------------------------------------------------------------------------
interface iat_req_if
   import iat_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [REQ_TYPE_WIDTH-1:0] req_type;
   logic [INDEX_WIDTH-1:0]    index;
   logic [VALUE_WIDTH-1:0]    value;

   modport source (output valid, output req_type, output index, output value,
                   input ready);
   modport sink   (input valid, input req_type, input index, input value,
                   output ready);
endinterface

interface iat_rsp_if
   import iat_pkg::*;
();
   logic                         valid;
   logic                         ready;
   logic [VALUE_WIDTH-1:0]       read_value;
   logic [COUNT_FIELD_WIDTH-1:0] found_index;
   logic [COUNT_FIELD_WIDTH-1:0] fill_level;
   logic [STATUS_WIDTH-1:0]      status;

   modport source (output valid, output read_value, output found_index,
                   output fill_level, output status, input ready);
   modport sink   (input valid, input read_value, input found_index,
                   input fill_level, input status, output ready);
endinterface

[sv/indexed_array_table_unit.sv]
// ----------------------------------------------------------------------------
// Indexed array table unit
// Fixed-capacity element array with a fill count, held in one RAM. Push, pop,
// get and set touch one entry; insert and delete shift entries through the
// RAM one per cycle; find scans from the bottom for the first match.
// ----------------------------------------------------------------------------
//  Channel    Direction  Transaction content
//  req_chan   in         req_type, index, value
//  rsp_chan   out        read_value, found_index, fill_level, status
//
//  After reset the unit zeroes every RAM entry before it takes its first
//  request transaction.
//  Push, pop, set and errors pass through the execute and finish states to
//  the response register; get adds the get state. Insert and delete walk
//  fill - index and fill - index - 1 entries, find up to fill entries.
//  The next request is taken once the response is in the output register;
//  a stalled response blocks only the following result.
// ----------------------------------------------------------------------------
module indexed_array_table_unit
   import iat_pkg::*;
#(
   parameter int CAPACITY   = 256,
   parameter int ELEM_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   iat_req_if.sink   req_chan,
   iat_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   state_type               state_ff, state_in;
   logic [CW-1:0]           used_ff, used_in;
   logic [REQ_TYPE_WIDTH-1:0] op_ff, op_in;
   logic [INDEX_WIDTH-1:0]  idx_ff, idx_in;
   logic [ELEM_WIDTH-1:0]   val_ff, val_in;
   logic [AW-1:0]           ptr_ff, ptr_in;
   logic [CW-1:0]           rem_ff, rem_in;
   logic                    pend_ff, pend_in;
   logic [AW-1:0]           pend_addr_ff, pend_addr_in;
   logic [VALUE_WIDTH-1:0]  res_read_ff, res_read_in;
   logic [CW-1:0]           res_found_ff, res_found_in;
   status_type              res_status_ff, res_status_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]       rsp_read_ff;
   logic [COUNT_FIELD_WIDTH-1:0] rsp_found_ff;
   logic [COUNT_FIELD_WIDTH-1:0] rsp_fill_ff;
   logic [STATUS_WIDTH-1:0]      rsp_status_ff;

   logic                    mem_we;
   logic [AW-1:0]           mem_waddr;
   logic [ELEM_WIDTH-1:0]   mem_wdata;
   logic                    mem_re;
   logic [AW-1:0]           mem_raddr;
   logic [ELEM_WIDTH-1:0]   mem_rdata;

   logic                    req_accept;
   logic                    slot_free;
   logic                    rsp_load;
   logic [CMP_WIDTH-1:0]    idx11, used11, cap11;
   logic                    idx_ge_cap, idx_ge_used, idx_gt_used, is_full, is_empty;
   status_type              exec_status;
   logic                    is_insert, is_find;
   logic                    match, walk_done;
   logic [AW-1:0]           idx_addr;
   logic [EXT_WIDTH-1:0]    val_ext, rd_ext;
   logic [CMP_WIDTH-1:0]    found_ext, fill_ext;

   iat_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_load       = (state_ff == S_FIN) && slot_free;

   assign idx11       = CMP_WIDTH'(idx_ff);
   assign used11      = CMP_WIDTH'(used_ff);
   assign cap11       = CMP_WIDTH'(CAPACITY);
   assign idx_ge_cap  = idx11 >= cap11;
   assign idx_ge_used = idx11 >= used11;
   assign idx_gt_used = idx11 > used11;
   assign is_full     = used11 == cap11;
   assign is_empty    = used_ff == '0;
   assign idx_addr    = idx_ff[AW-1:0];

   assign is_insert = (op_ff == OP_INSERT);
   assign is_find   = (op_ff == OP_FIND);
   assign match     = pend_ff && (mem_rdata == val_ff);
   assign walk_done = is_find ? (match || (rem_ff == '0 && !pend_ff))
                              : (rem_ff == '0 && !pend_ff);

   assign val_ext = EXT_WIDTH'(req_chan.value);
   assign rd_ext  = EXT_WIDTH'(mem_rdata);

   always_comb begin
      unique case (op_ff)
         OP_PUSH:   exec_status = is_full ? ST_FULL : ST_OK;
         OP_POP:    exec_status = is_empty ? ST_EMPTY : ST_OK;
         OP_INSERT: begin
            if (idx_ge_cap || idx_gt_used) begin
               exec_status = ST_RANGE;
            end else if (is_full) begin
               exec_status = ST_FULL;
            end else begin
               exec_status = ST_OK;
            end
         end
         OP_DELETE: begin
            if (is_empty) begin
               exec_status = ST_EMPTY;
            end else if (idx_ge_used) begin
               exec_status = ST_RANGE;
            end else begin
               exec_status = ST_OK;
            end
         end
         OP_GET:    exec_status = idx_ge_used ? ST_RANGE : ST_OK;
         OP_SET:    exec_status = idx_ge_cap ? ST_RANGE : ST_OK;
         default:   exec_status = ST_OK;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (ptr_ff == AW'(CAPACITY - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_status != ST_OK) begin
               state_in = S_FIN;
            end else begin
               unique case (op_ff)
                  OP_GET:                       state_in = S_GET;
                  OP_INSERT, OP_DELETE, OP_FIND: state_in = S_WALK;
                  default:                      state_in = S_FIN;
               endcase
            end
         end
         S_GET:  state_in = S_FIN;
         S_WALK: begin
            if (walk_done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      mem_we        = 1'b0;
      mem_waddr     = ptr_ff;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = ptr_ff;
      used_in       = used_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      ptr_in        = ptr_ff;
      rem_in        = rem_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      res_read_in   = res_read_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            ptr_in    = ptr_ff + 1'b1;
         end
         S_IDLE: begin
            if (req_accept) begin
               op_in  = req_chan.req_type;
               idx_in = req_chan.index;
               val_in = val_ext[ELEM_WIDTH-1:0];
            end
         end
         S_EXEC: begin
            res_status_in = exec_status;
            res_read_in   = '0;
            res_found_in  = '0;
            if (exec_status == ST_OK) begin
               unique case (op_ff)
                  OP_PUSH: begin
                     mem_we    = 1'b1;
                     mem_waddr = used_ff[AW-1:0];
                     mem_wdata = val_ff;
                     used_in   = used_ff + 1'b1;
                  end
                  OP_POP: begin
                     mem_we    = 1'b1;
                     mem_waddr = AW'(used11 - 1'b1);
                     used_in   = used_ff - 1'b1;
                  end
                  OP_SET: begin
                     mem_we    = 1'b1;
                     mem_waddr = idx_addr;
                     mem_wdata = val_ff;
                     if (idx_ge_used) begin
                        used_in = CW'(idx11 + 1'b1);
                     end
                  end
                  OP_GET: begin
                     mem_re    = 1'b1;
                     mem_raddr = idx_addr;
                  end
                  OP_INSERT: begin
                     rem_in = CW'(used11 - idx11);
                     ptr_in = AW'(used11 - 1'b1);
                  end
                  OP_DELETE: begin
                     rem_in = CW'(used11 - idx11 - 1'b1);
                     ptr_in = AW'(idx11 + 1'b1);
                  end
                  OP_FIND: begin
                     rem_in       = used_ff;
                     ptr_in       = '0;
                     res_found_in = CW'(CAPACITY);
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_GET: begin
            res_read_in = rd_ext[VALUE_WIDTH-1:0];
         end
         S_WALK: begin
            if (rem_ff != '0) begin
               mem_re       = 1'b1;
               mem_raddr    = ptr_ff;
               ptr_in       = is_insert ? ptr_ff - 1'b1 : ptr_ff + 1'b1;
               rem_in       = rem_ff - 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff;
            end
            if (is_find) begin
               if (match) begin
                  res_found_in = CW'(pend_addr_ff);
               end
            end else if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = is_insert ? pend_addr_ff + 1'b1 : pend_addr_ff - 1'b1;
               mem_wdata = mem_rdata;
            end else if (rem_ff == '0) begin
               mem_we    = 1'b1;
               mem_waddr = is_insert ? idx_addr : AW'(used11 - 1'b1);
               mem_wdata = is_insert ? val_ff : '0;
               used_in   = is_insert ? used_ff + 1'b1 : used_ff - 1'b1;
            end
         end
         S_FIN: begin
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);
   assign found_ext    = CMP_WIDTH'(res_found_ff);
   assign fill_ext     = CMP_WIDTH'(used_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         used_ff      <= '0;
         ptr_ff       <= '0;
         rem_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         ptr_ff       <= ptr_in;
         rem_ff       <= rem_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      val_ff        <= val_in;
      pend_addr_ff  <= pend_addr_in;
      res_read_ff   <= res_read_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_read_ff   <= res_read_ff;
         rsp_found_ff  <= found_ext[COUNT_FIELD_WIDTH-1:0];
         rsp_fill_ff   <= fill_ext[COUNT_FIELD_WIDTH-1:0];
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.read_value  = rsp_read_ff;
   assign rsp_chan.found_index = rsp_found_ff;
   assign rsp_chan.fill_level  = rsp_fill_ff;
   assign rsp_chan.status      = rsp_status_ff;

   // The fill count never passes the capacity.
   assert property (@(posedge clock) disable iff (reset) used11 <= cap11)
      else $error("fill count above capacity");

   // Every read of the table lies below the fill count.
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff != S_CLEAR && mem_re) |-> CMP_WIDTH'(mem_raddr) < used11)
      else $error("table read above fill count");

   // A shift never writes the entry it reads in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == S_WALK && mem_we && mem_re) |-> mem_waddr != mem_raddr)
      else $error("shift read and write collide");

   // The fill count changes only while a request executes.
   assert property (@(posedge clock) disable iff (reset)
                    !(state_ff == S_EXEC || state_ff == S_WALK) |=> $stable(used_ff))
      else $error("fill count changed outside execution");

   // Leaving the finish state always leaves a response in the output register.
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == S_FIN && state_in == S_IDLE) |=> rsp_valid_ff)
      else $error("response lost on completion");

endmodule

[sv/iat_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module iat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
